[hw/rtl/sgce_pkg.sv]
// Package: shared constants, word types and fixed-point helpers for the cell exchange block.
package sgce_pkg;

  localparam int FRAC_BITS          = 16;
  localparam int NUM_W              = 32 + FRAC_BITS + 1;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = 32 / DIV_BITS_PER_STAGE;
  localparam int DIV_LAT            = DIV_STAGES + 2;
  localparam int PIPE_LAT           = 3 * DIV_LAT + 11;

  localparam logic [30:0] ONE_Q31 = 31'(64'd1 << FRAC_BITS);
  localparam logic [16:0] ONE_Q17 = 17'(64'd1 << FRAC_BITS);

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -(64'sd2147483648);

  typedef enum logic [2:0] {
    REG_CELL_AREA,
    REG_SAT_COND,
    REG_VISC,
    REG_MIN_DEPTH,
    REG_THETA_SAT,
    REG_THETA_RES,
    REG_TIME_STEP
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] surface_level;
    logic signed [31:0] bed_elevation;
    logic signed [31:0] gw_pressure_head;
    logic [16:0]        water_content;
    logic [30:0]        top_layer_thickness;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] limited_flux;
    logic signed [31:0] new_surface_level;
    logic [30:0]        new_ponded_depth;
    logic [16:0]        new_water_content;
    logic signed [31:0] exchanged_volume;
  } out_word_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [31:0] w;
    logic [30:0] d;
    logic        neg;
    logic        ovf;
  } div_stage_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) return 32'sh7fffffff;
    else if (v < S32_MIN) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // floor of the scaled product, saturated
  function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FRAC_BITS;
    return sat32(s);
  endfunction

  function automatic logic [30:0] clamp_depth(input logic signed [32:0] d);
    if (d < 0) return '0;
    else if (d > 33'sd2147483647) return '1;
    else return d[30:0];
  endfunction

  // |a| scaled by 2^FRAC_BITS, once more doubled when extra is set
  function automatic logic [NUM_W-1:0] to_mag(input logic signed [31:0] a, input logic extra);
    logic signed [32:0] ax;
    logic [NUM_W-1:0]   m;
    ax = 33'(a);
    if (ax < 0) ax = -ax;
    m = NUM_W'(ax[31:0]) << FRAC_BITS;
    if (extra) m = m << 1;
    return m;
  endfunction

  // restoring division, DIV_BITS_PER_STAGE quotient bits
  function automatic div_stage_t div_iter(input div_stage_t s);
    div_stage_t  t;
    logic [31:0] r;
    t = s;
    for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
      r = {t.rem, t.w[31]};
      if (r >= {1'b0, t.d}) begin
        r   = r - {1'b0, t.d};
        t.w = {t.w[30:0], 1'b1};
      end else begin
        t.w = {t.w[30:0], 1'b0};
      end
      t.rem = r[30:0];
    end
    return t;
  endfunction

endpackage

[hw/rtl/sgce_in_if.sv]
// Interface: input cell word channel.
interface sgce_in_if import sgce_pkg::*;;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/sgce_out_if.sv]
// Interface: result word channel.
interface sgce_out_if import sgce_pkg::*;;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/sgce_div.sv]
// Pipelined saturating fixed-point divider, one word per cycle while en is high.
module sgce_div import sgce_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [NUM_W-1:0]   num_mag,
  input  logic               num_neg,
  input  logic [30:0]        den,
  output logic signed [31:0] quo
);

  div_stage_t         st_r [DIV_STAGES+1];
  div_stage_t         st0_nxt;
  logic [30:0]        d_eff;
  logic [NUM_W-33:0]  high;
  logic [31:0]        q;
  logic signed [31:0] quo_r, quo_nxt;

  always_comb begin
    d_eff       = (den == '0) ? 31'd1 : den;
    high        = num_mag[NUM_W-1:32];
    st0_nxt.d   = d_eff;
    st0_nxt.neg = num_neg;
    st0_nxt.ovf = 32'(high) >= 32'(d_eff);   // quotient needs more than 32 bits
    st0_nxt.rem = 31'(high);
    st0_nxt.w   = num_mag[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) st_r[0] <= st0_nxt;
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) st_r[k] <= div_iter(st_r[k-1]);
    end
  end

  always_comb begin
    q = st_r[DIV_STAGES].w;
    if (st_r[DIV_STAGES].neg) begin
      if (st_r[DIV_STAGES].ovf || q > 32'h80000000) quo_nxt = 32'sh80000000;
      else quo_nxt = $signed(-q);
    end else begin
      if (st_r[DIV_STAGES].ovf || q[31]) quo_nxt = 32'sh7fffffff;
      else quo_nxt = $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

[hw/rtl/surface_groundwater_cell_exchange.sv]
// Top level: surface/groundwater exchange pipeline for one grid cell per word.
// Throughput: one word per cycle unless held; three chained dividers, 2 quotient bits
// per stage. The whole pipe holds while a finished result waits on out_m.ready.
// Reset (rst_n low, synchronous): all stage valid bits cleared, registers to defaults
// (area, viscosity factor, theta_sat and time step 1.0; the rest 0). No clearing pass.
module surface_groundwater_cell_exchange import sgce_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sgce_in_if.sink      in_s,
  sgce_out_if.source   out_m,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // per-cell context carried alongside the arithmetic
  typedef struct packed {
    logic signed [31:0] eta;
    logic signed [31:0] bed;
    logic [16:0]        wc;
    logic [30:0]        depth;
    logic [30:0]        vol;
    logic signed [31:0] q;
    logic signed [31:0] exch;
  } ctx_t;

  // ---------------- configuration registers ----------------
  logic [30:0] area_r, cond_r, visc_r, mind_r, dt_r;
  logic [16:0] tsat_r, tres_r;
  logic        cfg_wr;
  cfg_reg_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r <= ONE_Q31;
      cond_r <= '0;
      visc_r <= ONE_Q31;
      mind_r <= '0;
      tsat_r <= ONE_Q17;
      tres_r <= '0;
      dt_r   <= ONE_Q31;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CELL_AREA: area_r <= pwdata[30:0];
        REG_SAT_COND:  cond_r <= pwdata[30:0];
        REG_VISC:      visc_r <= pwdata[30:0];
        REG_MIN_DEPTH: mind_r <= pwdata[30:0];
        REG_THETA_SAT: tsat_r <= pwdata[16:0];
        REG_THETA_RES: tres_r <= pwdata[16:0];
        REG_TIME_STEP: dt_r   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CELL_AREA: prdata = 32'(area_r);
      REG_SAT_COND:  prdata = 32'(cond_r);
      REG_VISC:      prdata = 32'(visc_r);
      REG_MIN_DEPTH: prdata = 32'(mind_r);
      REG_THETA_SAT: prdata = 32'(tsat_r);
      REG_THETA_RES: prdata = 32'(tres_r);
      REG_TIME_STEP: prdata = 32'(dt_r);
      default:       prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // Single enable for every stage: the pipe moves unless the output word is stuck.
  logic                stage_en;
  logic [PIPE_LAT:1]   vld_r;

  assign stage_en   = !vld_r[PIPE_LAT] || out_m.ready;
  assign in_s.ready = stage_en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (stage_en) vld_r <= {vld_r[PIPE_LAT-1:1], in_s.valid};
  end

  // ---------------- stage 1: ponded depth, area*K ----------------
  logic signed [31:0] s1_eta_r, s1_bed_r, s1_head_r;
  logic [16:0]        s1_wc_r;
  logic [30:0]        s1_dz_r, s1_depth_r;
  logic [61:0]        s1_prod_r;

  always_ff @(posedge clk) begin
    if (stage_en) begin
      s1_eta_r   <= in_s.data.surface_level;
      s1_bed_r   <= in_s.data.bed_elevation;
      s1_head_r  <= in_s.data.gw_pressure_head;
      s1_wc_r    <= in_s.data.water_content;
      s1_dz_r    <= in_s.data.top_layer_thickness;
      s1_depth_r <= clamp_depth(33'(in_s.data.surface_level) - 33'(in_s.data.bed_elevation));
      s1_prod_r  <= 62'(area_r) * 62'(cond_r);
    end
  end

  // ---------------- stage 2: *visc, head - depth, area*dz ----------------
  logic signed [31:0] s2_eta_r, s2_bed_r, s2_hd_r, s2_hd_nxt, p1;
  logic [16:0]        s2_wc_r;
  logic [30:0]        s2_dz_r, s2_depth_r;
  logic signed [63:0] s2_prod_r, s2_prod_nxt;
  logic [61:0]        s2_vprod_r;

  always_comb begin
    p1          = qmul_sat($signed(64'(s1_prod_r)));
    s2_prod_nxt = 64'(p1) * $signed(64'(visc_r));
    s2_hd_nxt   = sat32(64'(s1_head_r) - $signed(64'(s1_depth_r)));
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      s2_eta_r   <= s1_eta_r;
      s2_bed_r   <= s1_bed_r;
      s2_wc_r    <= s1_wc_r;
      s2_dz_r    <= s1_dz_r;
      s2_depth_r <= s1_depth_r;
      s2_hd_r    <= s2_hd_nxt;
      s2_prod_r  <= s2_prod_nxt;
      s2_vprod_r <= 62'(area_r) * 62'(s1_dz_r);
    end
  end

  // ---------------- stage 3: *(head - depth), cell volume ----------------
  logic signed [31:0] p2, vol_full;
  logic signed [63:0] s3_prod_r;
  logic [30:0]        s3_dz_r;
  ctx_t               s3_ctx_nxt, s3_ctx_r;

  always_comb begin
    p2               = qmul_sat(s2_prod_r);
    vol_full         = qmul_sat($signed(64'(s2_vprod_r)));
    s3_ctx_nxt       = '0;
    s3_ctx_nxt.eta   = s2_eta_r;
    s3_ctx_nxt.bed   = s2_bed_r;
    s3_ctx_nxt.wc    = s2_wc_r;
    s3_ctx_nxt.depth = s2_depth_r;
    s3_ctx_nxt.vol   = vol_full[30:0];
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      s3_prod_r <= 64'(p2) * 64'(s2_hd_r);
      s3_dz_r   <= s2_dz_r;
      s3_ctx_r  <= s3_ctx_nxt;
    end
  end

  // ---------------- stage 4: raw Darcy numerator ----------------
  logic signed [31:0] s4_p3_r;
  logic [30:0]        s4_dz_r;
  ctx_t               s4_ctx_r;

  always_ff @(posedge clk) begin
    if (stage_en) begin
      s4_p3_r  <= qmul_sat(s3_prod_r);
      s4_dz_r  <= s3_dz_r;
      s4_ctx_r <= s3_ctx_r;
    end
  end

  // divide by half the layer thickness
  logic signed [31:0] qa;

  sgce_div u_div_flux (
    .clk(clk), .en(stage_en),
    .num_mag(to_mag(s4_p3_r, 1'b1)), .num_neg(s4_p3_r[31]), .den(s4_dz_r),
    .quo(qa)
  );

  // context delay lines matched to the divider latency
  ctx_t ctxa_r [DIV_LAT];
  ctx_t ctxc_r [DIV_LAT];
  ctx_t ctxd_r [DIV_LAT];
  ctx_t s24_ctx_r, s45_ctx_r;

  // ---------------- stage 23: dry check, limit products ----------------
  ctx_t               ca, s23_ctx_nxt, s23_ctx_r;
  logic signed [17:0] tsw, wtr;
  logic [61:0]        s23_ps_r;
  logic signed [63:0] s23_pg_r, s23_pp_r;

  always_comb begin
    ca          = ctxa_r[DIV_LAT-1];
    s23_ctx_nxt = ca;
    // a dry cell cannot infiltrate
    if (ca.depth <= mind_r && qa < 0) s23_ctx_nxt.q = '0;
    else s23_ctx_nxt.q = qa;
    tsw = $signed({1'b0, tsat_r}) - $signed({1'b0, ca.wc});
    wtr = $signed({1'b0, ca.wc}) - $signed({1'b0, tres_r});
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      s23_ctx_r <= s23_ctx_nxt;
      s23_ps_r  <= 62'(ca.depth) * 62'(area_r);
      s23_pg_r  <= 64'(tsw) * $signed(64'(ca.vol));
      s23_pp_r  <= 64'(wtr) * $signed(64'(ca.vol));
    end
  end

  // ---------------- stage 24: scaled limit volumes ----------------
  logic signed [31:0] s24_as_r, s24_ag_r, s24_ap_r;

  always_ff @(posedge clk) begin
    if (stage_en) begin
      s24_as_r  <= qmul_sat($signed(64'(s23_ps_r)));
      s24_ag_r  <= qmul_sat(s23_pg_r);
      s24_ap_r  <= qmul_sat(s23_pp_r);
      s24_ctx_r <= s23_ctx_r;
    end
  end

  // limits per unit time: surface water, soil headroom, drainable water
  logic signed [31:0] ds, dg, dp;

  sgce_div u_div_lim_s (
    .clk(clk), .en(stage_en),
    .num_mag(to_mag(s24_as_r, 1'b0)), .num_neg(s24_as_r[31]), .den(dt_r), .quo(ds)
  );
  sgce_div u_div_lim_g (
    .clk(clk), .en(stage_en),
    .num_mag(to_mag(s24_ag_r, 1'b0)), .num_neg(s24_ag_r[31]), .den(dt_r), .quo(dg)
  );
  sgce_div u_div_lim_p (
    .clk(clk), .en(stage_en),
    .num_mag(to_mag(s24_ap_r, 1'b0)), .num_neg(s24_ap_r[31]), .den(dt_r), .quo(dp)
  );

  // ---------------- stage 43: apply limits ----------------
  ctx_t               cc, s43_ctx_nxt, s43_ctx_r;
  logic signed [31:0] lim_s, lim_g, lim_i;

  always_comb begin
    cc          = ctxc_r[DIV_LAT-1];
    s43_ctx_nxt = cc;
    lim_s       = sat32(-64'(ds));
    lim_g       = sat32(-64'(dg));
    lim_i       = (lim_s > lim_g) ? lim_s : lim_g;
    if ($signed(cc.q) < 0) begin
      s43_ctx_nxt.q = ($signed(cc.q) > lim_i) ? cc.q : lim_i;
    end else if ($signed(cc.q) > 0) begin
      s43_ctx_nxt.q = ($signed(cc.q) < dp) ? cc.q : dp;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) s43_ctx_r <= s43_ctx_nxt;
  end

  // ---------------- stages 44, 45: exchanged volume ----------------
  logic signed [63:0] s44_prod_r;
  ctx_t               s44_ctx_r, s45_ctx_nxt;

  always_ff @(posedge clk) begin
    if (stage_en) begin
      s44_prod_r <= 64'($signed(s43_ctx_r.q)) * $signed(64'(dt_r));
      s44_ctx_r  <= s43_ctx_r;
    end
  end

  always_comb begin
    s45_ctx_nxt      = s44_ctx_r;
    s45_ctx_nxt.exch = qmul_sat(s44_prod_r);
  end

  always_ff @(posedge clk) begin
    if (stage_en) s45_ctx_r <= s45_ctx_nxt;
  end

  // level change and water content change
  logic signed [31:0] da, dv;

  sgce_div u_div_area (
    .clk(clk), .en(stage_en),
    .num_mag(to_mag(s45_ctx_r.exch, 1'b0)), .num_neg(s45_ctx_r.exch[31]),
    .den(area_r), .quo(da)
  );
  sgce_div u_div_vol (
    .clk(clk), .en(stage_en),
    .num_mag(to_mag(s45_ctx_r.exch, 1'b0)), .num_neg(s45_ctx_r.exch[31]),
    .den(s45_ctx_r.vol), .quo(dv)
  );

  always_ff @(posedge clk) begin
    if (stage_en) begin
      ctxa_r[0] <= s4_ctx_r;
      ctxc_r[0] <= s24_ctx_r;
      ctxd_r[0] <= s45_ctx_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        ctxa_r[i] <= ctxa_r[i-1];
        ctxc_r[i] <= ctxc_r[i-1];
        ctxd_r[i] <= ctxd_r[i-1];
      end
    end
  end

  // ---------------- stage 64: new level, raw water content ----------------
  ctx_t               cd, s64_ctx_r;
  logic signed [31:0] s64_neta_r, s64_nwc_r;

  assign cd = ctxd_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (stage_en) begin
      s64_neta_r <= sat32(64'($signed(cd.eta)) + 64'(da));
      s64_nwc_r  <= sat32($signed(64'(cd.wc)) - 64'(dv));
      s64_ctx_r  <= cd;
    end
  end

  // ---------------- stage 65: output register ----------------
  logic signed [31:0] wc_lo, wc_hi;
  out_word_t          out_nxt, out_r;

  always_comb begin
    wc_lo = (s64_nwc_r > $signed(32'(tres_r))) ? s64_nwc_r : $signed(32'(tres_r));
    // clamp to saturation last, so crossed bounds give theta_sat
    wc_hi = (wc_lo < $signed(32'(tsat_r))) ? wc_lo : $signed(32'(tsat_r));
    out_nxt.limited_flux      = s64_ctx_r.q;
    out_nxt.new_surface_level = s64_neta_r;
    out_nxt.new_ponded_depth  = clamp_depth(33'(s64_neta_r) - 33'($signed(s64_ctx_r.bed)));
    out_nxt.new_water_content = wc_hi[16:0];
    out_nxt.exchanged_volume  = s64_ctx_r.exch;
  end

  always_ff @(posedge clk) begin
    if (stage_en) out_r <= out_nxt;
  end

  assign out_m.valid = vld_r[PIPE_LAT];
  assign out_m.data  = out_r;

`ifndef ASSERT_OFF
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !stage_en |=> $stable(vld_r))
    else $error("pipe valid bits moved during stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_s.valid && in_s.ready |=> vld_r[1])
    else $error("accepted word missing in stage 1");

  a_zero_flux: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && out_m.data.limited_flux == 0 |-> out_m.data.exchanged_volume == 0)
    else $error("volume exchanged without flux");

  a_wc_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid |-> out_m.data.new_water_content <= tsat_r)
    else $error("water content above saturation");
`endif

endmodule
